/* design/asr_pkg.sv */
// Shared constants and types for the audio stutter repeater.
package asr_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_PROBABILITY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_STEP        = 2'd3;

    // Field widths
    localparam int SEG_W  = 15;
    localparam int RPT_W  = 8;
    localparam int PROB_W = 17;
    localparam int STEP_W = 15;
    localparam int DRAW_W = 16;
    localparam int RNUM_W = RPT_W + 1;

    // Read offset arithmetic: step times repeat number, then the position sum
    localparam int PROD_W = STEP_W + RNUM_W + 1;
    localparam int OFF_W  = PROD_W + 1;

    // Register reset values
    localparam logic [SEG_W-1:0]  SEG_RST  = 15'd4096;
    localparam logic [RPT_W-1:0]  RPT_RST  = 8'd0;
    localparam logic [PROB_W-1:0] PROB_RST = 17'd65536;
    localparam logic [STEP_W-1:0] STEP_RST = 15'd0;

    // Control carried alongside the history read into the result stage
    typedef struct packed {
        logic valid;     // result stage holds a request
        logic use_hist;  // replay from history instead of passing the input
        logic hist_ok;   // history entry has been written since reset
    } t_s2_ctl;

endpackage

/* design/audio_stutter_repeater.sv */
// Top level of the audio stutter (beat repeat) effect.
//
// One sample request is taken per clock and one result leaves per clock when
// the output side is ready. A request is captured in the input register at the
// edge that accepts it. The next edge at which the result stage advances
// performs the history read and loads the result register, which then holds
// the result until it is taken. The rate is set by the single history ring,
// which takes one read and one write per request. Every sample
// is stored in the ring. A trigger that wins the random draw starts a stutter:
// the next segment_length samples pass through, then that segment is replayed
// repeat_count times, each replay shifted by advance_step times the replay
// number. The ring needs no clearing pass after reset: a fill mark tracks which
// entries have been written, and an entry not yet written reads as zero.
// HISTORY_DEPTH must be a power of two. Configuration writes take effect at the
// next clock edge and are expected only while no request is in flight.
module audio_stutter_repeater #(
    parameter int HISTORY_DEPTH = 16384,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [asr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [asr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // sample request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    input  logic                              i_clock_trigger,
    input  logic [asr_pkg::DRAW_W-1:0]        i_random_draw,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_sample_out
);

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [asr_pkg::SEG_W-1:0]         r_seg_len;
    logic [asr_pkg::RPT_W-1:0]         r_rpt_cnt;
    logic [asr_pkg::PROB_W-1:0]        r_trig_prob;
    logic signed [asr_pkg::STEP_W-1:0] r_adv_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len   <= asr_pkg::SEG_RST;
            r_rpt_cnt   <= asr_pkg::RPT_RST;
            r_trig_prob <= asr_pkg::PROB_RST;
            r_adv_step  <= asr_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                asr_pkg::CFG_SEGMENT_LENGTH: begin
                    r_seg_len <= i_cfg_data[asr_pkg::SEG_W-1:0];
                end
                asr_pkg::CFG_REPEAT_COUNT: begin
                    r_rpt_cnt <= i_cfg_data[asr_pkg::RPT_W-1:0];
                end
                asr_pkg::CFG_TRIGGER_PROBABILITY: begin
                    r_trig_prob <= i_cfg_data[asr_pkg::PROB_W-1:0];
                end
                asr_pkg::CFG_ADVANCE_STEP: begin
                    r_adv_step <= i_cfg_data[asr_pkg::STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow: stage 1 is the input register, stage 2 the result.
    // Advance stage 2 whenever it is empty or being drained; stage 1 may
    // fill while empty even if stage 2 is stalled.
    // ------------------------------------------------------------------
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic                          r_s1_trig;
    logic [asr_pkg::DRAW_W-1:0]    r_s1_draw;

    asr_pkg::t_s2_ctl              r_s2;
    logic signed [SAMPLE_BITS-1:0] r_s2_sample;

    logic adv_s2;
    logic load_s1;
    logic step;

    assign adv_s2     = !r_s2.valid || i_out_ready;
    assign load_s1    = !r_s1_valid || adv_s2;
    assign step       = r_s1_valid && adv_s2;
    assign o_in_ready = i_rst_n && load_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load_s1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Hold the payload once captured; take a new one only on acceptance
    always_ff @(posedge i_clk) begin
        if (load_s1 && i_in_valid) begin
            r_s1_sample <= i_sample_in;
            r_s1_trig   <= i_clock_trigger;
            r_s1_draw   <= i_random_draw;
        end
    end

    // ------------------------------------------------------------------
    // Stutter state
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]          r_wr_pos;
    logic                       r_wrapped;   // ring has been fully written
    logic [ADDR_W-1:0]          r_trig_pos;
    logic [asr_pkg::RNUM_W-1:0] r_rep_num;
    logic [asr_pkg::RPT_W-1:0]  r_rep_pend;
    logic [asr_pkg::SEG_W-1:0]  r_seg_rem;

    logic [ADDR_W-1:0]          n_trig_pos;
    logic [asr_pkg::RNUM_W-1:0] n_rep_num;
    logic [asr_pkg::RPT_W-1:0]  n_rep_pend;
    logic [asr_pkg::SEG_W-1:0]  n_seg_rem;
    logic                       use_hist;
    logic                       start;

    // A draw below the probability starts (or restarts) a stutter
    assign start = r_s1_trig && ({1'b0, r_s1_draw} < r_trig_prob);

    always_comb begin
        n_trig_pos = r_trig_pos;
        n_rep_num  = r_rep_num;
        n_rep_pend = r_rep_pend;
        n_seg_rem  = r_seg_rem;

        if (start) begin
            n_rep_num  = '0;
            n_rep_pend = r_rpt_cnt;
            n_seg_rem  = r_seg_len;
            n_trig_pos = r_wr_pos;
        end

        if (n_rep_pend != '0) begin
            // Count down the segment; at its end move to the next replay
            if (n_seg_rem != '0) begin
                n_seg_rem = n_seg_rem - asr_pkg::SEG_W'(1);
            end
            if (n_seg_rem == '0) begin
                n_rep_num = n_rep_num + asr_pkg::RNUM_W'(1);
                if (n_rep_num > {1'b0, n_rep_pend}) begin
                    // last replay done: pass this sample through
                    n_rep_pend = '0;
                    n_rep_num  = '0;
                end else begin
                    n_seg_rem = r_seg_len;
                end
            end
        end

        use_hist = (n_rep_num != '0);
    end

    // Replay read position: trigger - 1 - remaining + step * replay number,
    // taken modulo the ring depth by dropping the upper bits
    logic signed [asr_pkg::PROD_W-1:0] prod;
    logic [asr_pkg::OFF_W-1:0]         pos_sum;
    logic [ADDR_W-1:0]                 rd_addr;
    logic                              hist_ok;

    assign prod    = asr_pkg::PROD_W'(r_adv_step)
                   * asr_pkg::PROD_W'($signed({1'b0, n_rep_num}));
    assign pos_sum = asr_pkg::OFF_W'(n_trig_pos)
                   - asr_pkg::OFF_W'(1)
                   - asr_pkg::OFF_W'(n_seg_rem)
                   + {prod[asr_pkg::PROD_W-1], prod};
    assign rd_addr = pos_sum[ADDR_W-1:0];

    // Entry was written if the ring has wrapped or it lies below the write
    // position (the current sample is written after this read)
    assign hist_ok = r_wrapped || (rd_addr < r_wr_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos   <= '0;
            r_wrapped  <= 1'b0;
            r_trig_pos <= '0;
            r_rep_num  <= '0;
            r_rep_pend <= '0;
            r_seg_rem  <= '0;
        end else if (step) begin
            r_wr_pos   <= r_wr_pos + ADDR_W'(1);
            if (r_wr_pos == {ADDR_W{1'b1}}) begin
                r_wrapped <= 1'b1;
            end
            r_trig_pos <= n_trig_pos;
            r_rep_num  <= n_rep_num;
            r_rep_pend <= n_rep_pend;
            r_seg_rem  <= n_seg_rem;
        end
    end

    // ------------------------------------------------------------------
    // History ring
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] ring_data;

    asr_ring #(
        .DEPTH  (HISTORY_DEPTH),
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_en      (step),
        .i_wr_addr (r_wr_pos),
        .i_wr_data (r_s1_sample),
        .i_rd_addr (rd_addr),
        .o_rd_data (ring_data)
    );

    // ------------------------------------------------------------------
    // Result stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else if (adv_s2) begin
            r_s2.valid    <= r_s1_valid;
            r_s2.use_hist <= use_hist;
            r_s2.hist_ok  <= hist_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_s2_sample <= r_s1_sample;
        end
    end

    // Replayed entries never written since reset read as silence
    assign o_out_valid  = r_s2.valid;
    assign o_sample_out = r_s2.use_hist
                        ? (r_s2.hist_ok ? $signed(ring_data) : '0)
                        : r_s2_sample;

endmodule

/* design/asr_ring.sv */
// History ring memory: one write and one registered read per enabled cycle.
module asr_ring #(
    parameter int DEPTH  = 16384,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Read-first: a read of the address being written returns the old entry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data          <= r_mem[i_rd_addr];
            r_mem[i_wr_addr]   <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/asr_checker.sv */
// Port-level checker for the audio stutter repeater, bound to the top level.
module asr_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_sample_out
);

    // Requests accepted but not yet delivered
    logic [1:0] r_in_flight;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
        end else begin
            r_in_flight <= r_in_flight + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("result dropped or changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_in_flight != 2'd0)
        else $error("result without an accepted request");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_flight != 2'd3)
        else $error("more requests in flight than the pipeline holds");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input refused while the result side can move");

endmodule

bind audio_stutter_repeater asr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_asr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out)
);
